### hw/rtl/http_body_chunked_decoder_unit_assert.svh
// assertion macros for the chunked body decoder checker
// depends on a clock named clock and a reset named reset in the including scope
`ifndef HTTP_BODY_CHUNKED_DECODER_UNIT_ASSERT_SVH
`define HTTP_BODY_CHUNKED_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define HBCD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hbcd check failed");

// next-cycle implication
`define HBCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hbcd check failed");

`endif

### hw/rtl/hbcd_pkg.sv
// shared types and constants for the chunked http body decoder
// no dependencies
`default_nettype none

package hbcd_pkg;

   localparam int MAX_HEX_DIGITS = 8;
   localparam int LENGTH_WIDTH   = 48;
   localparam int CSR_WIDTH      = 48;
   localparam int CHUNK_WIDTH    = 32;
   localparam int DIGIT_WIDTH    = 4;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;

   typedef enum logic [1:0] {
      CMD_DATA  = 2'd0,
      CMD_END   = 2'd1,
      CMD_START = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_CLOSE   = 2'd0,
      MODE_LENGTH  = 2'd1,
      MODE_CHUNKED = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_READY = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_BODY_MODE      = 2'd0,
      CSR_CONTENT_LENGTH = 2'd1,
      CSR_DECHUNK        = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_SIZE = 3'd0,
      PH_EXT  = 3'd1,
      PH_DATA = 3'd2,
      PH_TAIL = 3'd3,
      PH_LAST = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       keep;
      logic       is_payload;
      logic [1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/http_body_chunked_decoder_unit.sv
// chunked / length / close delimited http body decoder, one byte per request
// depends on hbcd_pkg
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_data   (hbcd_pkg::req_type)
//   rsp_      out        rsp_valid/rsp_ready   rsp_data   (hbcd_pkg::rsp_type)
//   csr_      in         csr_we                csr_index, csr_wdata
//
// one request per cycle while req_ready is high; its result shows in the rsp register in the next cycle
// the framing state update is one pass of logic in front of the rsp register
// req_ready drops while a result waits and rsp_ready is low, and during reset
// synchronous reset clears control and framing state, no clearing pass
`default_nettype none

module http_body_chunked_decoder_unit
   import hbcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire req_type              req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata
);

   logic [1:0]             body_mode_ff;
   logic [CSR_WIDTH-1:0]   content_length_ff;
   logic                   dechunk_ff;

   phase_type              phase_ff, phase_in;
   logic [CHUNK_WIDTH-1:0] chunk_size_ff, chunk_size_in;
   logic [CHUNK_WIDTH-1:0] chunk_count_ff, chunk_count_in;
   logic [DIGIT_WIDTH-1:0] digit_count_ff, digit_count_in;
   logic                   saw_cr_ff, saw_cr_in;
   logic [LENGTH_WIDTH-1:0] body_count_ff, body_count_in;
   logic                   done_ff, done_in;
   logic                   error_ff, error_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   fire;
   logic [LENGTH_WIDTH-1:0] clen;
   logic [7:0]             b;
   logic                   is_hex;
   logic [3:0]             hex_val;
   logic [CHUNK_WIDTH-1:0] count_next;
   logic                   ok;
   logic                   pay;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign fire      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign clen      = LENGTH_WIDTH'(content_length_ff);
   assign b         = req_data.data_byte;
   assign count_next = chunk_count_ff + 1'b1;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (b >= CHAR_0 && b <= CHAR_9) begin
         hex_val = 4'(b - CHAR_0);
      end else if (b >= CHAR_LO_A && b <= CHAR_LO_F) begin
         hex_val = 4'(b - CHAR_LO_A + 8'd10);
      end else if (b >= CHAR_UP_A && b <= CHAR_UP_F) begin
         hex_val = 4'(b - CHAR_UP_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      chunk_size_in  = chunk_size_ff;
      chunk_count_in = chunk_count_ff;
      digit_count_in = digit_count_ff;
      saw_cr_in      = saw_cr_ff;
      body_count_in  = body_count_ff;
      done_in        = done_ff;
      error_in       = error_ff;
      ok             = 1'b1;
      pay            = 1'b0;
      rsp_data_in.out_byte   = 8'd0;
      rsp_data_in.keep       = 1'b0;
      rsp_data_in.is_payload = 1'b0;

      if (req_data.command == CMD_START) begin
         phase_in       = PH_SIZE;
         chunk_size_in  = '0;
         chunk_count_in = '0;
         digit_count_in = '0;
         saw_cr_in      = 1'b0;
         body_count_in  = '0;
         done_in        = 1'b0;
         error_in       = 1'b0;
      end else if (req_data.command == CMD_DATA) begin
         rsp_data_in.out_byte = b;
         if (!error_ff) begin
            if (body_mode_ff == MODE_CHUNKED) begin
               unique case (phase_ff)
                  PH_SIZE: begin
                     if (is_hex) begin
                        if (digit_count_ff >= DIGIT_WIDTH'(MAX_HEX_DIGITS)) begin
                           ok = 1'b0;
                        end else begin
                           digit_count_in = digit_count_ff + 1'b1;
                           chunk_size_in  = {chunk_size_ff[CHUNK_WIDTH-5:0], hex_val};
                        end
                     end else if (digit_count_ff == '0) begin
                        ok = 1'b0;
                     end else begin
                        chunk_count_in = '0;
                        if (chunk_size_ff == '0) begin
                           phase_in = PH_LAST;
                           done_in  = 1'b1;
                        end else begin
                           // this byte opens the extension scan
                           phase_in  = PH_EXT;
                           saw_cr_in = (b == CHAR_CR);
                        end
                     end
                  end
                  PH_EXT: begin
                     if (saw_cr_ff && b == CHAR_LF) begin
                        saw_cr_in      = 1'b0;
                        chunk_count_in = '0;
                        phase_in       = PH_DATA;
                     end else begin
                        saw_cr_in = (b == CHAR_CR);
                     end
                  end
                  PH_DATA: begin
                     pay            = 1'b1;
                     chunk_count_in = count_next;
                     if (count_next == chunk_size_ff) begin
                        saw_cr_in = 1'b0;
                        phase_in  = PH_TAIL;
                     end
                  end
                  PH_TAIL: begin
                     if (saw_cr_ff && b == CHAR_LF) begin
                        saw_cr_in      = 1'b0;
                        digit_count_in = '0;
                        chunk_size_in  = '0;
                        phase_in       = PH_SIZE;
                     end else begin
                        saw_cr_in = (b == CHAR_CR);
                     end
                  end
                  default: begin
                     // last chunk seen, trailers pass as framing
                     done_in = 1'b1;
                  end
               endcase
               if (!ok) begin
                  error_in = 1'b1;
               end else if (pay) begin
                  rsp_data_in.keep       = 1'b1;
                  rsp_data_in.is_payload = 1'b1;
               end else begin
                  rsp_data_in.keep = !dechunk_ff;
               end
            end else if (body_mode_ff == MODE_LENGTH) begin
               if (body_count_ff < clen) begin
                  body_count_in          = body_count_ff + 1'b1;
                  rsp_data_in.keep       = 1'b1;
                  rsp_data_in.is_payload = 1'b1;
               end
            end else if (!done_ff) begin
               rsp_data_in.keep       = 1'b1;
               rsp_data_in.is_payload = 1'b1;
            end
         end
      end else if (req_data.command == CMD_END) begin
         if (!error_ff) begin
            if (body_mode_ff == MODE_CHUNKED) begin
               if (!done_ff) begin
                  error_in = 1'b1;
               end
            end else if (body_mode_ff == MODE_LENGTH) begin
               if (body_count_ff < clen) begin
                  error_in = 1'b1;
               end
            end else begin
               done_in = 1'b1;
            end
         end
      end

      // length mode completes as soon as the count reaches the length
      if (body_mode_ff == MODE_LENGTH && body_count_in >= clen) begin
         done_in = 1'b1;
      end

      if (error_in) begin
         rsp_data_in.status = ST_ERROR;
      end else if (done_in) begin
         rsp_data_in.status = ST_DONE;
      end else begin
         rsp_data_in.status = ST_READY;
      end

      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mode_ff      <= MODE_CLOSE;
         content_length_ff <= '0;
         dechunk_ff        <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BODY_MODE:      body_mode_ff      <= csr_wdata[1:0];
            CSR_CONTENT_LENGTH: content_length_ff <= csr_wdata;
            CSR_DECHUNK:        dechunk_ff        <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE;
         chunk_size_ff  <= '0;
         chunk_count_ff <= '0;
         digit_count_ff <= '0;
         saw_cr_ff      <= 1'b0;
         body_count_ff  <= '0;
         done_ff        <= 1'b0;
         error_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff       <= phase_in;
            chunk_size_ff  <= chunk_size_in;
            chunk_count_ff <= chunk_count_in;
            digit_count_ff <= digit_count_in;
            saw_cr_ff      <= saw_cr_in;
            body_count_ff  <= body_count_in;
            done_ff        <= done_in;
            error_ff       <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/hbcd_checker.sv
// port-level checks for the chunked body decoder, bound to http_body_chunked_decoder_unit
// depends on hbcd_pkg and http_body_chunked_decoder_unit_assert.svh
`default_nettype none

`include "http_body_chunked_decoder_unit_assert.svh"

module hbcd_checker
   import hbcd_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire req_type              req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire rsp_type              rsp_data
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   `HBCD_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `HBCD_ASSERT_NEXT(a_req_gives_rsp, req_fire, rsp_valid)
   `HBCD_ASSERT_NEXT(a_ctrl_no_byte, req_fire && req_data.command != CMD_DATA,
      !rsp_data.keep && !rsp_data.is_payload && rsp_data.out_byte == 8'd0)
   `HBCD_ASSERT_NEXT(a_start_clears_error, req_fire && req_data.command == CMD_START,
      rsp_data.status != ST_ERROR)
   `HBCD_ASSERT_NOW(a_payload_kept, rsp_valid && rsp_data.is_payload, rsp_data.keep)

endmodule

bind http_body_chunked_decoder_unit hbcd_checker u_hbcd_checker (.*);

`default_nettype wire
